@@ rtl/core/bpa_pkg.sv @@
package bpa_pkg;

   localparam int MAX_PAGES_DEF = 128 * 1024;

   localparam int WORD_W  = 32;
   localparam int BIT_W   = 5;
   localparam int FUNC_W  = 2;
   localparam int PAGE_W  = 18;
   localparam int FIRST_W = 17;
   localparam int COUNT_W = 18;
   localparam int WIDX_W  = PAGE_W - BIT_W;
   localparam int POP_W   = BIT_W + 1;

   localparam logic [PAGE_W-1:0] TRACK_RESET = PAGE_W'(MAX_PAGES_DEF);

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_RESERVE = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_READ,
      ST_MODIFY,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               hit;
      logic [PAGE_W-1:0]  start;
      logic [COUNT_W-1:0] need;
      logic [PAGE_W-1:0]  run_start;
   } scan_res_type;

   typedef struct packed {
      logic              set;
      logic [WIDX_W-1:0] first_w;
      logic [WIDX_W-1:0] last_w;
      logic [BIT_W-1:0]  lo;
      logic [BIT_W-1:0]  hi;
   } mark_ctl_type;

   // bits below b
   function automatic logic [WORD_W-1:0] thermo_lt(input logic [BIT_W-1:0] b);
      logic [WORD_W-1:0] m;
      for (int i = 0; i < WORD_W; i++) begin
         m[i] = (BIT_W'(i) < b);
      end
      return m;
   endfunction

   // bits up to and including b
   function automatic logic [WORD_W-1:0] thermo_le(input logic [BIT_W-1:0] b);
      logic [WORD_W-1:0] m;
      for (int i = 0; i < WORD_W; i++) begin
         m[i] = (BIT_W'(i) <= b);
      end
      return m;
   endfunction

endpackage

@@ rtl/core/bpa_if.sv @@
interface bpa_req_if import bpa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [FIRST_W-1:0] first_page;
   logic [COUNT_W-1:0] page_count;

   modport source (output valid, func, first_page, page_count, input ready);
   modport sink   (input valid, func, first_page, page_count, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               status;
   logic [FIRST_W-1:0] start_page;
   logic [COUNT_W-1:0] free_pages;

   modport source (output valid, status, start_page, free_pages, input ready);
   modport sink   (input valid, status, start_page, free_pages, output ready);
endinterface

interface bpa_csr_if import bpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/bpa_ram.sv @@
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bpa_scan_eval.sv @@
module bpa_scan_eval import bpa_pkg::*; (
   input  logic [WORD_W-1:0]  data,
   input  logic [WIDX_W-1:0]  word,
   input  logic               last,
   input  logic [BIT_W-1:0]   lbit,
   input  logic [COUNT_W-1:0] need,
   input  logic [COUNT_W-1:0] count,
   input  logic [PAGE_W-1:0]  run_start,
   output scan_res_type       res
);

   logic [WORD_W-1:0] free_bits;
   logic [WORD_W-1:0] pmask;
   logic [WORD_W-1:0] kmask;
   logic [WORD_W-1:0] fits;
   logic              pre_hit;
   logic              in_hit;
   logic [BIT_W-1:0]  in_idx;
   logic [POP_W-1:0]  lead;

   always_comb begin
      // pages at or past the limit read as used
      free_bits = ~data & (last ? thermo_le(lbit) : '1);

      for (int i = 0; i < WORD_W; i++) begin
         pmask[i] = (need > COUNT_W'(i));
         kmask[i] = (count > COUNT_W'(i));
      end

      // run carried in from lower words finishes at the bottom of this word
      pre_hit = (need <= COUNT_W'(WORD_W)) && (&(free_bits | ~pmask));

      // runs lying wholly inside this word
      for (int i = 0; i < WORD_W; i++) begin
         fits[i] = (count <= COUNT_W'(WORD_W)) && (&((free_bits >> i) | ~kmask));
      end
      in_hit = |fits;
      in_idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (fits[i]) begin
            in_idx = BIT_W'(i);
         end
      end

      // free pages at the top of the word start the next run
      lead = POP_W'(WORD_W);
      for (int i = 0; i < WORD_W; i++) begin
         if (!free_bits[i]) begin
            lead = POP_W'(WORD_W - 1 - i);
         end
      end

      res.hit   = pre_hit || in_hit;
      res.start = pre_hit ? run_start : {word, in_idx};
      if (&free_bits) begin
         res.need      = need - COUNT_W'(WORD_W);
         res.run_start = run_start;
      end else begin
         res.need      = count - COUNT_W'(lead);
         res.run_start = PAGE_W'({1'b0, word, {BIT_W{1'b0}}}
                                 + (PAGE_W + 1)'(POP_W'(WORD_W) - lead));
      end
   end

endmodule

@@ rtl/core/bpa_word_update.sv @@
module bpa_word_update import bpa_pkg::*; (
   input  logic [WORD_W-1:0] old_word,
   input  logic [WIDX_W-1:0] word,
   input  mark_ctl_type      ctl,
   output logic [WORD_W-1:0] new_word,
   output logic [POP_W-1:0]  delta
);

   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] flips;

   always_comb begin
      mask = (word == ctl.first_w ? ~thermo_lt(ctl.lo) : '1)
           & (word == ctl.last_w  ?  thermo_le(ctl.hi) : '1);
      new_word = ctl.set ? (old_word | mask) : (old_word & ~mask);
      flips    = old_word ^ new_word;
      delta    = '0;
      for (int i = 0; i < WORD_W; i++) begin
         delta = delta + POP_W'(flips[i]);
      end
   end

endmodule

@@ rtl/core/bitmap_page_allocator_top.sv @@
// after reset a clearing pass writes every word of the used map to all ones,
// with no request taken; count resets to zero
// free/reserve: read, modify and count each word touched, in that order
// allocate: scan words up to a hit, then read, modify and count each word marked;
// a miss scans up to the limit, rounded up to words; a refused or unused code goes to done
// one request at a time, the next accepted once the result is registered
module bitmap_page_allocator_top import bpa_pkg::*; #(
   parameter int MAX_PAGES = MAX_PAGES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_bus,
   bpa_rsp_if.source rsp_bus,
   bpa_csr_if.sink   csr_bus
);

   localparam int WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

   state_type          state_ff, state_in;
   logic [PAGE_W-1:0]  tracked_ff, tracked_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [PAGE_W-1:0]  first_ff, first_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PAGE_W-1:0]  lim_ff, lim_in;
   logic [WIDX_W-1:0]  lw_ff, lw_in;
   logic [BIT_W-1:0]   lbit_ff, lbit_in;
   logic [WIDX_W:0]    issue_ff, issue_in;
   logic               eval_v_ff, eval_v_in;
   logic [WIDX_W-1:0]  eval_w_ff, eval_w_in;
   logic [COUNT_W-1:0] need_ff, need_in;
   logic [PAGE_W-1:0]  run_ff, run_in;
   logic               status_ff, status_in;
   logic [PAGE_W-1:0]  start_ff, start_in;
   mark_ctl_type       ctl_ff, ctl_in;
   logic [WIDX_W-1:0]  word_ff, word_in;
   logic [POP_W-1:0]   delta_ff, delta_in;
   logic               rsp_v_ff, rsp_v_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [FIRST_W-1:0] rsp_start_ff, rsp_start_in;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_free_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [WORD_W-1:0]  ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [WORD_W-1:0]  ram_rdata;

   logic [PAGE_W-1:0]  lim_now;
   logic [PAGE_W-1:0]  lim_m1;
   logic [PAGE_W:0]    range_sum;
   logic [PAGE_W-1:0]  range_end;
   logic [PAGE_W-1:0]  range_m1;
   logic               range_empty;
   logic               issuing;
   logic               rsp_free_slot;
   scan_res_type       scan_res;
   logic [WORD_W-1:0]  upd_word;
   logic [POP_W-1:0]   upd_delta;

   bpa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bpa_scan_eval u_scan (
      .data      (ram_rdata),
      .word      (eval_w_ff),
      .last      (eval_w_ff == lw_ff),
      .lbit      (lbit_ff),
      .need      (need_ff),
      .count     (count_ff),
      .run_start (run_ff),
      .res       (scan_res)
   );

   bpa_word_update u_update (
      .old_word (ram_rdata),
      .word     (word_ff),
      .ctl      (ctl_ff),
      .new_word (upd_word),
      .delta    (upd_delta)
   );

   assign lim_now = (32'(tracked_ff) > 32'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : tracked_ff;
   assign lim_m1  = lim_now - 1'b1;

   // range clipped at the limit
   assign range_sum   = {1'b0, first_ff} + {1'b0, count_ff};
   assign range_end   = (range_sum > {1'b0, lim_ff}) ? lim_ff : range_sum[PAGE_W-1:0];
   assign range_m1    = range_end - 1'b1;
   assign range_empty = (count_ff == '0) || (first_ff >= lim_ff);

   assign issuing       = (issue_ff <= {1'b0, lw_ff});
   assign rsp_free_slot = !rsp_v_ff || rsp_bus.ready;

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_v_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.start_page = rsp_start_ff;
   assign rsp_bus.free_pages = rsp_free_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.func == FUNC_ALLOC) begin
                  if (req_bus.page_count == '0 || req_bus.page_count > lim_now) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (req_bus.func == FUNC_FREE || req_bus.func == FUNC_RESERVE) begin
                  state_in = ST_PREP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (eval_v_ff) begin
               if (scan_res.hit) begin
                  state_in = ST_PREP;
               end else if (eval_w_ff == lw_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PREP: begin
            state_in = range_empty ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = (word_ff == ctl_ff.last_w) ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (rsp_free_slot) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      tracked_in    = tracked_ff;
      free_in       = free_ff;
      clr_in        = clr_ff;
      func_in       = func_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      lim_in        = lim_ff;
      lw_in         = lw_ff;
      lbit_in       = lbit_ff;
      issue_in      = issue_ff;
      eval_v_in     = 1'b0;
      eval_w_in     = eval_w_ff;
      need_in       = need_ff;
      run_in        = run_ff;
      status_in     = status_ff;
      start_in      = start_ff;
      ctl_in        = ctl_ff;
      word_in       = word_ff;
      delta_in      = delta_ff;
      rsp_v_in      = rsp_v_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_free_in   = rsp_free_ff;
      ram_we        = 1'b0;
      ram_waddr     = AW'(word_ff);
      ram_wdata     = upd_word;
      ram_raddr     = AW'(word_ff);

      if (csr_bus.valid) begin
         tracked_in = csr_bus.data;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '1;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               func_in   = req_bus.func;
               first_in  = {1'b0, req_bus.first_page};
               count_in  = req_bus.page_count;
               lim_in    = lim_now;
               lw_in     = lim_m1[PAGE_W-1:BIT_W];
               lbit_in   = lim_m1[BIT_W-1:0];
               issue_in  = '0;
               need_in   = req_bus.page_count;
               run_in    = '0;
               status_in = (req_bus.func == FUNC_ALLOC) ? STATUS_FAIL : STATUS_OK;
               start_in  = '0;
            end
         end
         ST_SCAN: begin
            // one word read per cycle; its data is evaluated the cycle after
            ram_raddr = AW'(issue_ff);
            eval_v_in = issuing;
            eval_w_in = issue_ff[WIDX_W-1:0];
            if (issuing) begin
               issue_in = issue_ff + 1'b1;
            end
            if (eval_v_ff) begin
               if (scan_res.hit) begin
                  status_in = STATUS_OK;
                  start_in  = scan_res.start;
                  first_in  = scan_res.start;
                  eval_v_in = 1'b0;
               end else begin
                  need_in = scan_res.need;
                  run_in  = scan_res.run_start;
               end
            end
         end
         ST_PREP: begin
            ctl_in.set     = (func_ff != FUNC_FREE);
            ctl_in.first_w = first_ff[PAGE_W-1:BIT_W];
            ctl_in.last_w  = range_m1[PAGE_W-1:BIT_W];
            ctl_in.lo      = first_ff[BIT_W-1:0];
            ctl_in.hi      = range_m1[BIT_W-1:0];
            word_in        = first_ff[PAGE_W-1:BIT_W];
         end
         ST_READ: begin
            ram_raddr = AW'(word_ff);
         end
         ST_MODIFY: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(word_ff);
            ram_wdata = upd_word;
            delta_in  = upd_delta;
         end
         ST_UPDATE: begin
            free_in = ctl_ff.set ? free_ff - COUNT_W'(delta_ff)
                                 : free_ff + COUNT_W'(delta_ff);
            word_in = word_ff + 1'b1;
         end
         ST_DONE: begin
            if (rsp_free_slot) begin
               rsp_v_in      = 1'b1;
               rsp_status_in = status_ff;
               rsp_start_in  = start_ff[FIRST_W-1:0];
               rsp_free_in   = free_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         tracked_ff <= TRACK_RESET;
         free_ff    <= '0;
         eval_v_ff  <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         tracked_ff <= tracked_in;
         free_ff    <= free_in;
         eval_v_ff  <= eval_v_in;
         rsp_v_ff   <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      first_ff      <= first_in;
      count_ff      <= count_in;
      lim_ff        <= lim_in;
      lw_ff         <= lw_in;
      lbit_ff       <= lbit_in;
      issue_ff      <= issue_in;
      eval_w_ff     <= eval_w_in;
      need_ff       <= need_in;
      run_ff        <= run_in;
      status_ff     <= status_in;
      start_ff      <= start_in;
      ctl_ff        <= ctl_in;
      word_ff       <= word_in;
      delta_ff      <= delta_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
   end

endmodule
